FILE: src/m4v_pkg.sv
package m4v_pkg;

   // Fixed-point format of coefficients and vector components
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PROD_W    = 2 * DATA_W;
   // A rescaled product drops the fraction bits of the second operand
   localparam int unsigned SHP_W     = PROD_W - FRAC_BITS;
   // Four rescaled products summed without loss
   localparam int unsigned SUM_W     = SHP_W + 2;

   localparam int unsigned DIM       = 4;
   localparam int unsigned NUM_REGS  = 8;
   localparam int unsigned CSR_W     = 64;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DATA_W-1:0] ONE_FIXED = DATA_W'(1) << FRAC_BITS;

   // Register indexes: two coefficients per register, row-major
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW1_COLS12 = 3'd0,
      CSR_ROW1_COLS34 = 3'd1,
      CSR_ROW2_COLS12 = 3'd2,
      CSR_ROW2_COLS34 = 3'd3,
      CSR_ROW3_COLS12 = 3'd4,
      CSR_ROW3_COLS34 = 3'd5,
      CSR_ROW4_COLS12 = 3'd6,
      CSR_ROW4_COLS34 = 3'd7
   } csr_index_type;

   typedef logic [NUM_REGS-1:0][CSR_W-1:0] csr_bank_type;

   typedef logic signed [DATA_W-1:0] coef_type;
   typedef coef_type coef_mat_type [DIM][DIM];

   typedef logic signed [SHP_W-1:0] prod_type;
   typedef prod_type prod_mat_type [DIM][DIM];

   typedef struct packed {
      logic signed [DATA_W-1:0] in_x;
      logic signed [DATA_W-1:0] in_y;
      logic signed [DATA_W-1:0] in_z;
      logic signed [DATA_W-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
      logic signed [DATA_W-1:0] out_w;
   } rsp_type;

   // Reset value of one register: identity matrix
   function automatic logic [CSR_W-1:0] csr_reset_value(input int unsigned idx);
      logic [CSR_W-1:0] val;
      int unsigned      row;
      int unsigned      col_lo;
      row    = idx >> 1;
      col_lo = (idx & 1) << 1;
      val    = '0;
      if (row == col_lo) begin
         val[DATA_W-1:0] = ONE_FIXED;
      end
      if (row == col_lo + 1) begin
         val[CSR_W-1:DATA_W] = ONE_FIXED;
      end
      return val;
   endfunction

endpackage

FILE: src/m4v_matrix_regs.sv
module m4v_matrix_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  m4v_pkg::csr_index_type       csr_index,
   input  logic [m4v_pkg::CSR_W-1:0]    csr_wdata,
   output m4v_pkg::coef_mat_type        coef
);
   import m4v_pkg::*;

   csr_bank_type regs_ff;
   logic         at_reset_value;

   // Coefficient registers, identity at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= csr_reset_value(i);
         end
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   // Split registers into a row-major coefficient grid
   for (genvar r = 0; r < DIM; r++) begin : g_row
      for (genvar c = 0; c < DIM; c++) begin : g_col
         assign coef[r][c] = regs_ff[r * 2 + (c >> 1)][(c & 1) * DATA_W +: DATA_W];
      end
   end

   always_comb begin
      at_reset_value = 1'b1;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (regs_ff[i] != csr_reset_value(i)) begin
            at_reset_value = 1'b0;
         end
      end
   end

   a_reset_identity : assert property (@(posedge clock) $past(reset) |-> at_reset_value)
      else $error("matrix not identity after reset");

   a_write_lands : assert property (@(posedge clock) disable iff (reset)
      (csr_we && !reset) |=> regs_ff[$past(csr_index)] == $past(csr_wdata))
      else $error("register write lost");

   a_hold_no_write : assert property (@(posedge clock) disable iff (reset)
      (!csr_we && !reset) |=> $stable(regs_ff))
      else $error("matrix changed without write");

endmodule

FILE: src/m4v_mul_stage.sv
module m4v_mul_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  m4v_pkg::req_type       req_data,
   input  m4v_pkg::coef_mat_type  coef,
   output logic                   prod_valid,
   input  logic                   prod_ready,
   output m4v_pkg::prod_mat_type  prod
);
   import m4v_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_type      in_data_ff;
   logic         prod_valid_ff;
   logic         prod_valid_in;
   prod_mat_type prod_ff;
   prod_mat_type prod_in;
   coef_type     vec [DIM];
   logic         prod_load;
   logic         in_load;

   // Each stage loads when empty or when the next one takes its item
   assign prod_load = !prod_valid_ff || prod_ready;
   assign in_load   = !in_valid_ff || prod_load;
   assign req_ready = in_load;

   assign in_valid_in   = in_load ? req_valid : in_valid_ff;
   assign prod_valid_in = prod_load ? in_valid_ff : prod_valid_ff;

   assign vec[0] = in_data_ff.in_x;
   assign vec[1] = in_data_ff.in_y;
   assign vec[2] = in_data_ff.in_z;
   assign vec[3] = in_data_ff.in_w;

   // Sixteen products, rescaled by dropping fraction bits (floor)
   for (genvar r = 0; r < DIM; r++) begin : g_row
      for (genvar c = 0; c < DIM; c++) begin : g_col
         logic signed [PROD_W-1:0] full;
         assign full          = PROD_W'(coef[r][c]) * PROD_W'(vec[c]);
         assign prod_in[r][c] = full[PROD_W-1:FRAC_BITS];
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   // Input and product registers
   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_data_ff <= req_data;
      end
      if (prod_load && in_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

FILE: src/m4v_sum_stage.sv
module m4v_sum_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   prod_valid,
   output logic                   prod_ready,
   input  m4v_pkg::prod_mat_type  prod,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output m4v_pkg::rsp_type       rsp_data
);
   import m4v_pkg::*;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic signed [SUM_W-1:0]  row_sum [DIM];
   coef_type                 row_sat [DIM];
   logic                     sum_load;

   assign sum_load     = !rsp_valid_ff || rsp_ready;
   assign prod_ready   = sum_load;
   assign rsp_valid_in = sum_load ? prod_valid : rsp_valid_ff;

   // Row sums, then clamp to the signed 32-bit range
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         row_sum[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
                    + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
         if (row_sum[r][SUM_W-1:DATA_W-1] == '0 || row_sum[r][SUM_W-1:DATA_W-1] == '1) begin
            row_sat[r] = row_sum[r][DATA_W-1:0];
         end else if (row_sum[r][SUM_W-1]) begin
            row_sat[r] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            row_sat[r] = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
      rsp_in.out_x = row_sat[0];
      rsp_in.out_y = row_sat[1];
      rsp_in.out_z = row_sat[2];
      rsp_in.out_w = row_sat[3];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (sum_load && prod_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/mat4_vec4_transform.sv
// 4x4 matrix times homogeneous vector, signed Q16.16 throughout.
//
// Request channel (req_valid/req_ready/req_data) carries x, y, z, w. Result
// channel (rsp_valid/rsp_ready/rsp_data) returns one vector per request: each
// component is one matrix row dotted with the input, every product floored
// after rescaling, the sum saturated to 32 bits.
// The matrix sits in eight 64-bit registers written through csr_we,
// csr_index and csr_wdata, two coefficients per register, row-major, lower
// column in the low word. Write them only while no request is in flight.
//
// A request passes the input register, the product register and the result
// register, in that order, before its result is valid.
// Throughput: one request per cycle while the receiver does not stall; sixteen
// parallel multipliers form all products of a request combinationally.
// Reset loads the identity matrix and empties the pipeline. When the
// receiver stalls, the three stages fill one by one and req_ready drops
// only once all three hold a request.
module mat4_vec4_transform (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  m4v_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output m4v_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  m4v_pkg::csr_index_type       csr_index,
   input  logic [m4v_pkg::CSR_W-1:0]    csr_wdata
);
   import m4v_pkg::*;

   coef_mat_type coef;
   prod_mat_type prod;
   logic         prod_valid;
   logic         prod_ready;

   // Coefficient registers
   m4v_matrix_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // Input register and products
   m4v_mul_stage u_mul (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .coef       (coef),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   // Row sums, saturation and result register
   m4v_sum_stage u_sum (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_empty_after_reset : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request refused without an output stall");

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request refused while output drains");

endmodule
